FILE: rtl/fmws_pkg.sv
// fmws_pkg: shared types, constants and the quarter-wave table builder
// for the waveform shaper; no dependencies
package fmws_pkg;

    localparam int DEF_PHASE_BITS     = 16;
    localparam int DEF_QTAB_ADDR_BITS = 8;
    localparam int SHAPE_W            = 4;
    localparam int SAMPLE_W           = 16;
    localparam int SMAG_W             = 15;
    localparam int SAT_MAX            = 32767;
    localparam int MID_DEPTH          = 2;
    localparam int OUT_DEPTH          = 2;

    // waveform selector codes
    localparam logic [SHAPE_W-1:0] SHAPE_SINE         = 4'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_HALF_SINE    = 4'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_ABS_SINE     = 4'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_QUARTER_SINE = 4'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_DOUBLE_SINE  = 4'd4;
    localparam logic [SHAPE_W-1:0] SHAPE_ABS_DOUBLE   = 4'd5;
    localparam logic [SHAPE_W-1:0] SHAPE_SQUARE       = 4'd6;
    localparam logic [SHAPE_W-1:0] SHAPE_HALF_COSINE  = 4'd7;
    localparam logic [SHAPE_W-1:0] SHAPE_ROUND_SQUARE = 4'd8;
    localparam logic [SHAPE_W-1:0] SHAPE_CUBIC_SAW    = 4'd9;

    // operation handed from front to back
    localparam int OP_W = 3;
    typedef enum logic [OP_W-1:0] {
        OP_SINE,
        OP_ABS,
        OP_ZERO,
        OP_POS_FULL,
        OP_NEG_FULL,
        OP_RSQ_POS,
        OP_RSQ_NEG,
        OP_SAW
    } op_t;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    // entry k of the quarter-wave table, sin(pi/2 * k / 2^abits) in Q15,
    // integer taylor series in Q30; evaluated at elaboration
    function automatic logic [SMAG_W-1:0] qtab_entry(input int unsigned k,
                                                     input int unsigned abits);
        longint unsigned x;
        longint unsigned t;
        longint          sum;
        longint unsigned r;
        x   = (64'(k) * HALF_PI_Q30) >> abits;
        t   = x;
        sum = longint'(x);
        for (int i = 0; i < 7; i++)
        begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / TAYLOR_DIV[i];
            if ((i % 2) == 0)
            begin
                sum = sum - longint'(t);
            end
            else
            begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (unsigned'(sum) + 64'd16384) >> 15;
        if (r > 64'(SAT_MAX))
        begin
            r = 64'(SAT_MAX);
        end
        return SMAG_W'(r);
    endfunction

endpackage

FILE: rtl/fm_operator_waveform_shaper_top.sv
// fm_operator_waveform_shaper_top: top level of the waveform shaper
// depends on fmws_pkg, fmws_front, fmws_fifo, fmws_back
//
// Turns a phase (unsigned fraction of one cycle, phase / 2^PHASE_BITS) into
// one signed Q1.15 sample of the waveform picked by the 4-bit wave_shape
// register: 0 sine, 1 half sine, 2 absolute sine, 3 quarter-pulse sine,
// 4 double-rate sine in the first half, 5 its absolute value, 6 square,
// 7 half-rate cosine, 8 rounded square, 9 cubic saw; 10 to 15 act as sine.
// Outputs saturate to +/-32767. Both sides look like queues: push a phase
// while full is low, take a sample with pop while empty is low. One
// transaction per clock is sustained in both directions while pop keeps
// up; a lone phase passes through the front queue, three back stages
// (table read, first squaring, second squaring plus shaping) and then
// the result queue. The sine values come from a quarter-wave table of
// 2^QUARTER_TABLE_ADDR_BITS + 1 entries built at elaboration, so reset
// needs no fill pass. wave_shape is written via cfg_wr_en / cfg_wr_data
// and must only change while no transaction is in flight.
module fm_operator_waveform_shaper_top
    import fmws_pkg::*;
#(
    parameter int PHASE_BITS              = DEF_PHASE_BITS,
    parameter int QUARTER_TABLE_ADDR_BITS = DEF_QTAB_ADDR_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [SHAPE_W-1:0]         cfg_wr_data,
    // phase input queue
    input  logic                       push,
    output logic                       full,
    input  logic [PHASE_BITS-1:0]      phase,
    // sample output queue
    output logic                       empty,
    input  logic                       pop,
    output logic signed [SAMPLE_W-1:0] sample
);

    localparam int AW    = QUARTER_TABLE_ADDR_BITS + 1;
    localparam int MW    = PHASE_BITS + 1;
    localparam int MID_W = OP_W + AW + 1 + MW;

    // front side, classified transaction
    op_t             f_op;
    logic [AW-1:0]   f_addr;
    logic            f_neg;
    logic [MW-1:0]   f_mag;

    // decoupling queue between front and back
    logic [MID_W-1:0] mid_wr_data;
    logic [MID_W-1:0] mid_rd_data;
    logic             mid_empty;
    logic             mid_pop;

    // back side view of the queue head
    op_t             b_op;
    logic [AW-1:0]   b_addr;
    logic            b_neg;
    logic [MW-1:0]   b_mag;

    // result side
    logic                       res_valid;
    logic signed [SAMPLE_W-1:0] res_sample;
    logic                       out_full;
    logic [SAMPLE_W-1:0]        out_rd_data;

    fmws_front #(
        .PHASE_BITS     (PHASE_BITS),
        .QTAB_ADDR_BITS (QUARTER_TABLE_ADDR_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .phase       (phase),
        .op          (f_op),
        .addr        (f_addr),
        .neg         (f_neg),
        .saw_mag     (f_mag)
    );

    // classified transaction packed as {op, addr, neg, mag}
    assign mid_wr_data = {f_op, f_addr, f_neg, f_mag};

    fmws_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (mid_wr_data),
        .rd_en   (mid_pop),
        .rd_data (mid_rd_data),
        .full    (full),
        .empty   (mid_empty)
    );

    assign b_mag  = mid_rd_data[MW-1:0];
    assign b_neg  = mid_rd_data[MW];
    assign b_addr = mid_rd_data[MW+1 +: AW];
    assign b_op   = op_t'(mid_rd_data[MID_W-1 -: OP_W]);

    fmws_back #(
        .PHASE_BITS     (PHASE_BITS),
        .QTAB_ADDR_BITS (QUARTER_TABLE_ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (~mid_empty),
        .in_pop     (mid_pop),
        .op_in      (b_op),
        .addr_in    (b_addr),
        .neg_in     (b_neg),
        .mag_in     (b_mag),
        .out_valid  (res_valid),
        .out_full   (out_full),
        .out_sample (res_sample)
    );

    // result queue, its head drives the sample port
    fmws_fifo #(
        .WIDTH (SAMPLE_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res_sample),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .full    (out_full),
        .empty   (empty)
    );

    assign sample = $signed(out_rd_data);

endmodule

FILE: rtl/fmws_fifo.sv
// fmws_fifo: small register queue used between front and back and on the
// result side; depends on nothing
module fmws_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/fmws_front.sv
// fmws_front: shape register and phase classification into a table
// address and a back-end operation; depends on fmws_pkg
module fmws_front
    import fmws_pkg::*;
#(
    parameter int PHASE_BITS     = DEF_PHASE_BITS,
    parameter int QTAB_ADDR_BITS = DEF_QTAB_ADDR_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [SHAPE_W-1:0]      cfg_wr_data,
    input  logic [PHASE_BITS-1:0]   phase,
    output op_t                     op,
    output logic [QTAB_ADDR_BITS:0] addr,
    output logic                    neg,
    output logic [PHASE_BITS:0]     saw_mag
);

    localparam int FINE_W = QTAB_ADDR_BITS + 2;
    localparam logic [QTAB_ADDR_BITS:0] QLEN = {1'b1, {QTAB_ADDR_BITS{1'b0}}};
    localparam logic [PHASE_BITS-1:0] QUARTER = {2'b01, {(PHASE_BITS-2){1'b0}}};
    localparam logic [PHASE_BITS:0]   ONE     = {1'b1, {PHASE_BITS{1'b0}}};

    logic [SHAPE_W-1:0]        wave_shape_reg;
    logic [SHAPE_W-1:0]        wave_shape_next;
    logic                      first_half;
    logic                      first_quarter;
    logic [PHASE_BITS-1:0]     lookup;
    logic [FINE_W-1:0]         fine;
    logic [QTAB_ADDR_BITS-1:0] off;
    logic [PHASE_BITS:0]       twice;
    logic                      saw_neg;

    assign wave_shape_next = cfg_wr_en ? cfg_wr_data : wave_shape_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_shape_reg <= SHAPE_SINE;
        end
        else
        begin
            wave_shape_reg <= wave_shape_next;
        end
    end

    assign first_half    = ~phase[PHASE_BITS-1];
    assign first_quarter = (phase[PHASE_BITS-1 -: 2] == 2'b00);

    always_comb
    begin
        lookup = phase;
        op     = OP_SINE;
        unique case (wave_shape_reg)
            SHAPE_HALF_SINE:    op = first_half ? OP_SINE : OP_ZERO;
            SHAPE_ABS_SINE:     op = OP_ABS;
            SHAPE_QUARTER_SINE: op = first_quarter ? OP_SINE : OP_ZERO;
            SHAPE_DOUBLE_SINE:
            begin
                lookup = {phase[PHASE_BITS-2:0], 1'b0};
                op     = first_half ? OP_SINE : OP_ZERO;
            end
            SHAPE_ABS_DOUBLE:
            begin
                lookup = {phase[PHASE_BITS-2:0], 1'b0};
                op     = first_half ? OP_ABS : OP_ZERO;
            end
            SHAPE_SQUARE:       op = first_half ? OP_POS_FULL : OP_NEG_FULL;
            SHAPE_HALF_COSINE:  lookup = {1'b0, phase[PHASE_BITS-1:1]} + QUARTER;
            SHAPE_ROUND_SQUARE: op = first_half ? OP_RSQ_POS : OP_RSQ_NEG;
            SHAPE_CUBIC_SAW:    op = OP_SAW;
            default:            op = OP_SINE;
        endcase
    end

    // cut the lookup phase to quadrant plus table offset
    if (PHASE_BITS >= FINE_W)
    begin : g_fine_down
        assign fine = lookup[PHASE_BITS-1 -: FINE_W];
    end
    else
    begin : g_fine_up
        assign fine = {lookup, {(FINE_W-PHASE_BITS){1'b0}}};
    end

    assign off  = fine[QTAB_ADDR_BITS-1:0];
    assign addr = fine[QTAB_ADDR_BITS] ? QLEN - {1'b0, off} : {1'b0, off};

    // saw magnitude |1 - 2x| in Q(PHASE_BITS)
    assign twice   = {phase, 1'b0};
    assign saw_neg = (twice > ONE);
    assign saw_mag = saw_neg ? twice - ONE : ONE - twice;

    assign neg = (op == OP_SAW) ? saw_neg : fine[QTAB_ADDR_BITS+1];

endmodule

FILE: rtl/fmws_back.sv
// fmws_back: three-stage execution pipeline: table read, squaring stages,
// shaping and saturation; depends on fmws_pkg
module fmws_back
    import fmws_pkg::*;
#(
    parameter int PHASE_BITS     = DEF_PHASE_BITS,
    parameter int QTAB_ADDR_BITS = DEF_QTAB_ADDR_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_pop,
    input  op_t                        op_in,
    input  logic [QTAB_ADDR_BITS:0]    addr_in,
    input  logic                       neg_in,
    input  logic [PHASE_BITS:0]        mag_in,
    output logic                       out_valid,
    input  logic                       out_full,
    output logic signed [SAMPLE_W-1:0] out_sample
);

    localparam int QLEN_N    = 1 << QTAB_ADDR_BITS;
    localparam int MW        = PHASE_BITS + 1;
    localparam int PW2       = 2 * MW;
    localparam logic [PW2-1:0] HALF_P = PW2'(1) << (PHASE_BITS - 1);
    localparam int CUBE_DOWN = (PHASE_BITS >= 15) ? PHASE_BITS - 15 : 0;
    localparam int CUBE_UP   = (PHASE_BITS >= 15) ? 0 : 15 - PHASE_BITS;
    localparam logic [31:0] SAW_RND = 32'((1 << CUBE_DOWN) >> 1);

    logic [SMAG_W-1:0] qtab [QLEN_N+1];

    for (genvar k = 0; k <= QLEN_N; k++)
    begin : g_qtab
        localparam logic [SMAG_W-1:0] ENTRY = qtab_entry(k, QTAB_ADDR_BITS);
        assign qtab[k] = ENTRY;
    end

    logic                adv;
    logic                v1_reg, v2_reg, v3_reg;
    op_t                 op1_reg, op2_reg;
    logic                neg1_reg, neg2_reg;
    logic [SMAG_W-1:0]   smag1_reg, smag2_reg;
    logic [MW-1:0]       m1_reg;
    logic [MW-1:0]       m2_reg;
    logic [MW-1:0]       m3_reg;
    logic [15:0]         d2_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    logic [PW2-1:0]      msq_prod;
    logic [MW-1:0]       m2_next;
    logic [PW2-1:0]      mcube_prod;
    logic [MW-1:0]       m3_next;
    logic [15:0]         dmag;
    logic [31:0]         dsq;
    logic [15:0]         d2_next;
    logic [31:0]         d4sq;
    logic [15:0]         d4;
    logic [16:0]         rsq;
    logic [SMAG_W-1:0]   rsq_sat;
    logic [31:0]         saw_q;
    logic [SMAG_W-1:0]   saw_sat;
    logic [SMAG_W-1:0]   mag_out;
    logic                negate;
    logic signed [SAMPLE_W-1:0] sample_next;

    // the whole pipe moves unless a finished result is blocked
    assign adv    = ~(v3_reg & out_full);
    assign in_pop = adv & in_valid;

    // stage 1 arithmetic: saw square
    assign msq_prod = PW2'(mag_in) * PW2'(mag_in);
    assign m2_next  = MW'((msq_prod + HALF_P) >> PHASE_BITS);

    // stage 2 arithmetic: saw cube, first rounded-square squaring
    assign mcube_prod = PW2'(m2_reg) * PW2'(m1_reg);
    assign m3_next    = MW'((mcube_prod + HALF_P) >> PHASE_BITS);
    assign dmag       = 16'd32768 - {1'b0, smag1_reg};
    assign dsq        = 32'(dmag) * 32'(dmag);
    assign d2_next    = 16'((dsq + 32'd16384) >> 15);

    // stage 3 arithmetic: second squaring, saw to q15
    assign d4sq    = 32'(d2_reg) * 32'(d2_reg);
    assign d4      = 16'((d4sq + 32'd16384) >> 15);
    assign rsq     = 17'd32768 - {1'b0, d4};
    assign rsq_sat = (rsq > 17'(SAT_MAX)) ? SMAG_W'(SAT_MAX) : rsq[SMAG_W-1:0];
    assign saw_q   = ((32'(m3_reg) + SAW_RND) >> CUBE_DOWN) << CUBE_UP;
    assign saw_sat = (saw_q > 32'(SAT_MAX)) ? SMAG_W'(SAT_MAX) : saw_q[SMAG_W-1:0];

    always_comb
    begin
        mag_out = '0;
        negate  = 1'b0;
        unique case (op2_reg)
            OP_SINE:
            begin
                mag_out = smag2_reg;
                negate  = neg2_reg;
            end
            OP_ABS:      mag_out = smag2_reg;
            OP_ZERO:     mag_out = '0;
            OP_POS_FULL: mag_out = SMAG_W'(SAT_MAX);
            OP_NEG_FULL:
            begin
                mag_out = SMAG_W'(SAT_MAX);
                negate  = 1'b1;
            end
            OP_RSQ_POS:  mag_out = rsq_sat;
            OP_RSQ_NEG:
            begin
                mag_out = rsq_sat;
                negate  = 1'b1;
            end
            OP_SAW:
            begin
                mag_out = saw_sat;
                negate  = neg2_reg;
            end
            default:     mag_out = '0;
        endcase
        sample_next = negate ? $signed(SAMPLE_W'(0) - {1'b0, mag_out})
                             : $signed({1'b0, mag_out});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg    <= op_in;
            neg1_reg   <= neg_in;
            smag1_reg  <= qtab[addr_in];
            m1_reg     <= mag_in;
            m2_reg     <= m2_next;
            op2_reg    <= op1_reg;
            neg2_reg   <= neg1_reg;
            smag2_reg  <= smag1_reg;
            m3_reg     <= m3_next;
            d2_reg     <= d2_next;
            sample_reg <= sample_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_sample = sample_reg;

endmodule

FILE: rtl/fmws_checker.sv
// fmws_checker: port-level assertions for the waveform shaper and the bind
// that attaches them to the top level; depends on fmws_pkg
module fmws_checker
    import fmws_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       push,
    input logic                       full,
    input logic                       empty,
    input logic                       pop,
    input logic signed [SAMPLE_W-1:0] sample
);

    // transactions accepted but not yet taken
    logic [3:0] occ_reg;
    logic [3:0] occ_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = push & ~full;
    assign out_acc = pop & ~empty;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_acc && !out_acc)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // saturation never lets the most negative code out
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> sample != $signed(16'h8000))
        else $error("sample outside +/-32767");

    // no result appears without a transaction behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == 4'd0 |-> empty)
        else $error("result shown with nothing outstanding");

    // a lone phase accepted with nothing outstanding makes a result show up
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && occ_reg == 4'd0) |-> ##5 !empty)
        else $error("result late");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(sample)))
        else $error("waiting result changed");

endmodule

bind fm_operator_waveform_shaper_top fmws_checker u_fmws_checker (.*);

FILE: verif/tb_fm_operator_waveform_shaper_top.sv
// tb_fm_operator_waveform_shaper_top: self-checking testbench for the waveform shaper
// depends on fmws_pkg and fm_operator_waveform_shaper_top; predicts every sample
// from the phase and the current wave_shape, with randomized push/pop idling
`timescale 1ns / 100ps

module tb_fm_operator_waveform_shaper_top;

    import fmws_pkg::*;

    localparam int PHASE_BITS     = DEF_PHASE_BITS;
    localparam int QTAB_BITS      = DEF_QTAB_ADDR_BITS;
    localparam int QLEN           = 1 << QTAB_BITS;
    // phase bits dropped before the table lookup, and q(PHASE_BITS) -> q15 shift
    localparam int FINE_SHIFT     = PHASE_BITS - QTAB_BITS - 2;
    localparam int CUBE_SHIFT     = PHASE_BITS - 15;
    localparam int ROUNDS         = 36;
    localparam int ROUND_ITEMS    = 20;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_CORNERS    = 14;

    // one predicted sample together with what produced it
    typedef struct packed {
        logic [PHASE_BITS-1:0]      phase;
        logic [SHAPE_W-1:0]         shape;
        logic signed [SAMPLE_W-1:0] value;
    } shaped_sample_t;

    // ------------------------------------------------------------------
    // scoreboard: own quarter-wave table, own copy of wave_shape, queue of
    // predicted samples in push order
    // ------------------------------------------------------------------
    class sample_scoreboard;
        shaped_sample_t     expected_samples[$];
        int                 quarter_wave[QLEN + 1];
        logic [SHAPE_W-1:0] shape;
        int                 mismatches;

        function new();
            longint unsigned x;
            longint unsigned t;
            longint          acc;
            longint unsigned r;
            // sin(pi/2 * k / QLEN) in q15 via an integer taylor series in q30
            for (int k = 0; k <= QLEN; k++)
            begin
                x   = (64'(k) * HALF_PI_Q30) / QLEN;
                t   = x;
                acc = longint'(x);
                for (int n = 1; n <= 7; n++)
                begin
                    t = (t * x) >> 30;
                    t = (t * x) >> 30;
                    t = t / (64'(2 * n) * 64'(2 * n + 1));
                    if (n % 2 == 1)
                    begin
                        acc = acc - longint'(t);
                    end
                    else
                    begin
                        acc = acc + longint'(t);
                    end
                end
                if (acc < 0)
                begin
                    acc = 0;
                end
                r = (unsigned'(acc) + 64'd16384) >> 15;
                if (r > 64'(SAT_MAX))
                begin
                    r = 64'(SAT_MAX);
                end
                quarter_wave[k] = int'(r);
            end
            shape      = SHAPE_SINE;
            mismatches = 0;
        endfunction

        function void set_shape(logic [SHAPE_W-1:0] value);
            shape = value;
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction

        // full-cycle sine from the mirrored quarter table
        function int table_sine(logic [PHASE_BITS-1:0] ph);
            int unsigned fine;
            int unsigned quad;
            int unsigned off;
            fine = int'(ph) >> FINE_SHIFT;
            quad = (fine >> QTAB_BITS) & 3;
            off  = fine & (QLEN - 1);
            case (quad)
                0: return quarter_wave[off];
                1: return quarter_wave[QLEN - off];
                2: return -quarter_wave[off];
                default: return -quarter_wave[QLEN - off];
            endcase
        endfunction

        // sign * (1 - (1 - |s|)^4), two squarings with round half up
        function int rounded_square(int s, bit first_half);
            longint d;
            longint d2;
            longint d4;
            int     r;
            d  = 32768 - ((s < 0) ? -s : s);
            d2 = (d * d + 16384) >> 15;
            d4 = (d2 * d2 + 16384) >> 15;
            r  = 32768 - int'(d4);
            if (r > SAT_MAX)
            begin
                r = SAT_MAX;
            end
            return first_half ? r : -r;
        endfunction

        // (1 - 2x)^3 on the magnitude, rounded, sign applied last
        function int cubic_saw(logic [PHASE_BITS-1:0] ph);
            longint one;
            longint twice;
            longint half;
            longint m;
            longint m2;
            longint m3;
            longint q;
            bit     neg;
            one   = longint'(1) << PHASE_BITS;
            twice = 2 * longint'(ph);
            neg   = (twice > one);
            m     = neg ? (twice - one) : (one - twice);
            half  = one >> 1;
            m2    = (m * m + half) >> PHASE_BITS;
            m3    = (m2 * m + half) >> PHASE_BITS;
            q     = (m3 + ((longint'(1) << CUBE_SHIFT) >> 1)) >> CUBE_SHIFT;
            if (q > SAT_MAX)
            begin
                q = SAT_MAX;
            end
            return neg ? -int'(q) : int'(q);
        endfunction

        function logic signed [SAMPLE_W-1:0] shape_sample(logic [PHASE_BITS-1:0] ph);
            bit                    first_half;
            bit                    first_quarter;
            logic [PHASE_BITS-1:0] doubled;
            logic [PHASE_BITS-1:0] half_rate;
            int                    s;
            int                    v;
            first_half    = !ph[PHASE_BITS-1];
            first_quarter = (ph[PHASE_BITS-1 -: 2] == 2'b00);
            doubled       = {ph[PHASE_BITS-2:0], 1'b0};
            half_rate     = (ph >> 1) + (PHASE_BITS'(1) << (PHASE_BITS - 2));
            s             = table_sine(ph);
            case (shape)
                SHAPE_HALF_SINE:    v = first_half ? s : 0;
                SHAPE_ABS_SINE:     v = (s < 0) ? -s : s;
                SHAPE_QUARTER_SINE: v = first_quarter ? s : 0;
                SHAPE_DOUBLE_SINE:  v = first_half ? table_sine(doubled) : 0;
                SHAPE_ABS_DOUBLE:
                begin
                    v = first_half ? table_sine(doubled) : 0;
                    v = (v < 0) ? -v : v;
                end
                SHAPE_SQUARE:       v = first_half ? SAT_MAX : -SAT_MAX;
                SHAPE_HALF_COSINE:  v = table_sine(half_rate);
                SHAPE_ROUND_SQUARE: v = rounded_square(s, first_half);
                SHAPE_CUBIC_SAW:    v = cubic_saw(ph);
                default:            v = s;
            endcase
            if (v > SAT_MAX)
            begin
                v = SAT_MAX;
            end
            if (v < -SAT_MAX)
            begin
                v = -SAT_MAX;
            end
            return SAMPLE_W'(v);
        endfunction

        function void note_phase(logic [PHASE_BITS-1:0] ph);
            shaped_sample_t rec;
            rec.phase = ph;
            rec.shape = shape;
            rec.value = shape_sample(ph);
            expected_samples.push_back(rec);
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] got);
            shaped_sample_t rec;
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("sample %0d popped with no transaction pending", got);
                end
            end
            else
            begin
                rec = expected_samples.pop_front();
                if (got !== rec.value)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("sample mismatch: shape %0d phase 0x%04h expected %0d got %0d",
                                 rec.shape, rec.phase, rec.value, got);
                    end
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [SHAPE_W-1:0]         cfg_wr_data = '0;
    logic                       push        = 1'b0;
    logic                       full;
    logic [PHASE_BITS-1:0]      phase       = '0;
    logic                       empty;
    logic                       pop         = 1'b0;
    logic signed [SAMPLE_W-1:0] sample;

    sample_scoreboard sb = new();

    // idling in percent of cycles, changed per stimulus phase
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int quiet_cycles      = 0;

    // quadrant edges, half and quarter tests, table endpoints, saw midpoint
    logic [PHASE_BITS-1:0] corner_phases [NUM_CORNERS] = '{
        16'h0000, 16'h0001, 16'h003F, 16'h0040, 16'h3FFF, 16'h4000, 16'h4001,
        16'h7FFF, 16'h8000, 16'h8001, 16'hBFFF, 16'hC000, 16'hFFC0, 16'hFFFF
    };

    fm_operator_waveform_shaper_top #(
        .PHASE_BITS              (PHASE_BITS),
        .QUARTER_TABLE_ADDR_BITS (QTAB_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .full        (full),
        .phase       (phase),
        .empty       (empty),
        .pop         (pop),
        .sample      (sample)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // result side: check each popped sample against the oldest prediction,
    // then choose pop for the next cycle
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_sample(sample);
        end
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            pop <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // watchdog: cycles in a row with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one phase transaction; idles first at the sender's rate, returns in
    // the cycle of acceptance with push still high
    task automatic send_phase(input logic [PHASE_BITS-1:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        phase <= value;
        forever
        begin
            @(posedge clk);
            if (!full)
            begin
                break;
            end
        end
        sb.note_phase(value);
    endtask

    // new wave_shape only once every sample in flight has been popped
    task automatic write_shape(input logic [SHAPE_W-1:0] value);
        push <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_shape(value);
    endtask

    // mostly uniform phases, with corners and their neighbors mixed in
    function automatic logic [PHASE_BITS-1:0] pick_phase();
        int sel;
        sel = $urandom_range(9);
        if (sel < 2)
        begin
            return corner_phases[$urandom_range(NUM_CORNERS - 1)];
        end
        else if (sel == 2)
        begin
            return corner_phases[$urandom_range(NUM_CORNERS - 1)]
                   + PHASE_BITS'($urandom_range(6)) - PHASE_BITS'(3);
        end
        return PHASE_BITS'($urandom_range(65535));
    endfunction

    initial
    begin
        logic [SHAPE_W-1:0] next_shape;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset shape (sine) over all corners
        sender_idle_pct   = 25;
        receiver_idle_pct = 60;
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            send_phase(corner_phases[i]);
        end
        // saw around its midpoint and ends, rounded square at its peaks
        write_shape(SHAPE_CUBIC_SAW);
        send_phase(16'h0000);
        send_phase(16'h7FFF);
        send_phase(16'h8000);
        send_phase(16'h8001);
        send_phase(16'hFFFF);
        write_shape(SHAPE_ROUND_SQUARE);
        send_phase(16'h0000);
        send_phase(16'h4000);
        send_phase(16'h8000);
        send_phase(16'hC000);
        send_phase(16'hFFFF);

        // random rounds; the first 32 walk every selector value twice, the rest pick at random
        for (int r = 0; r < ROUNDS; r++)
        begin
            if (r < ROUNDS / 3)
            begin
                sender_idle_pct   = 25;
                receiver_idle_pct = 60;
            end
            else if (r < 2 * ROUNDS / 3)
            begin
                sender_idle_pct   = 60;
                receiver_idle_pct = 25;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            if (r < 32)
            begin
                next_shape = SHAPE_W'((r * 7) % 16);
            end
            else
            begin
                next_shape = SHAPE_W'($urandom_range(15));
            end
            write_shape(next_shape);
            for (int i = 0; i < ROUND_ITEMS; i++)
            begin
                send_phase(pick_phase());
            end
        end

        // drain, then give stray samples a chance to show up
        push <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
